// ----- rtl/core/l1nog_pkg.sv -----
package l1nog_pkg;

   // Grid dimensions and the width of one signed offset.
   localparam int DIMS    = 3;
   localparam int OFF_W   = 5;
   localparam int DIST_W  = 4;
   // Signed width of the budget left to a dimension: distance minus the
   // magnitudes of all earlier dimensions, plus one bit of headroom.
   localparam int BUD_W   = 8;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = ((DIMS * OFF_W + 7) / 8) * 8;

   typedef logic signed [OFF_W-1:0] offset_type;
   typedef offset_type [DIMS-1:0]   point_type;

   typedef struct packed {
      logic      found;
      point_type point;
   } succ_type;

endpackage

// ----- rtl/core/l1nog_succ.sv -----
module l1nog_succ (
   input  l1nog_pkg::point_type          cur,
   input  logic [l1nog_pkg::DIST_W-1:0]  radius,
   output l1nog_pkg::succ_type           succ
);
   import l1nog_pkg::*;

   // The last dimension steps first; a dimension whose next value would
   // exceed the budget left by the earlier ones carries into the one before.
   always_comb begin
      logic                    found;
      point_type               nxt_pt;
      logic signed [BUD_W-1:0] budget;
      logic signed [BUD_W-1:0] val;
      logic signed [BUD_W-1:0] nxt;
      logic signed [BUD_W-1:0] mag;
      found  = 1'b0;
      nxt_pt = cur;
      for (int k = DIMS - 1; k >= 0; k--) begin
         budget = $signed({{(BUD_W-DIST_W){1'b0}}, radius});
         for (int j = 0; j < DIMS; j++) begin
            val = BUD_W'($signed(cur[j]));
            if (j < k) begin
               budget = budget - (val[BUD_W-1] ? -val : val);
            end
         end
         val = BUD_W'($signed(cur[k]));
         if (val == '0) begin
            nxt = BUD_W'(1);
         end else if (!val[BUD_W-1]) begin
            nxt = -val;
         end else begin
            nxt = -val + BUD_W'(1);
         end
         mag = nxt[BUD_W-1] ? -nxt : nxt;
         if (!found && (mag <= budget)) begin
            found     = 1'b1;
            nxt_pt[k] = nxt[OFF_W-1:0];
            for (int j = 0; j < DIMS; j++) begin
               if (j > k) begin
                  nxt_pt[j] = '0;
               end
            end
         end
      end
      succ.found = found;
      succ.point = nxt_pt;
   end

endmodule

// ----- rtl/core/l1_neighborhood_offset_generator.sv -----
// A word accepted on req is registered and appears on rsp in the next cycle.
// Throughput: one word per cycle while rsp is not stalled; the successor of the stored point and the
// look-ahead that flags the last point are both worked out in that cycle.
// Reset (synchronous, active high) clears the stored point and the run flag,
// empties the result register and sets the search distance to 1.
module l1_neighborhood_offset_generator (
   input  logic                               clock,
   input  logic                               reset,
   // csr_data: search_distance [3:0]
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [l1nog_pkg::DIST_W-1:0]       csr_data,
   // req_tdata: restart [0], zero fill above
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [l1nog_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: offset_dim0 [4:0], offset_dim1 [9:5], offset_dim2 [14:10],
   // zero fill above
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [l1nog_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: point_valid [0]
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);
   import l1nog_pkg::*;

   logic [DIST_W-1:0]     dist_ff;
   point_type             offset_ff, offset_in;
   logic                  active_ff, active_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic      accept;
   logic      restart;
   logic      run;
   logic      valid;
   point_type start_pt;
   succ_type  step;
   succ_type  probe;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign restart    = req_tdata[0];

   assign start_pt = restart ? point_type'('0) : offset_ff;
   assign run      = restart || active_ff;

   l1nog_succ u_step (
      .cur    (start_pt),
      .radius (dist_ff),
      .succ   (step)
   );

   // Look one point ahead to tell whether the new point ends the run.
   l1nog_succ u_probe (
      .cur    (step.point),
      .radius (dist_ff),
      .succ   (probe)
   );

   assign valid = run && step.found;

   always_comb begin
      offset_in    = offset_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         // A failed step leaves the point as it was, zero after a restart.
         offset_in    = run ? step.point : offset_ff;
         active_in    = valid;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         for (int j = 0; j < DIMS; j++) begin
            rsp_data_in[j*OFF_W +: OFF_W] = valid ? step.point[j] : offset_type'('0);
         end
         rsp_user_in = valid;
         rsp_last_in = valid && !probe.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff      <= DIST_W'(1);
         offset_ff    <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            dist_ff <= csr_data;
         end
         offset_ff    <= offset_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/core/l1nog_checker.sv -----
module l1nog_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [l1nog_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                               rsp_tuser,
   input logic                               rsp_tlast
);
   import l1nog_pkg::*;

   // Every accepted request is followed by a valid response word on the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request did not produce a response word");

   // A stalled result blocks new requests.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result register is stalled");

   // A word without a point carries no offset and no last flag.
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("empty word carries data or last flag");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response word changed");

endmodule

bind l1_neighborhood_offset_generator l1nog_checker u_l1nog_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
